[rtl/rlpm_pkg.sv]
package rlpm_pkg;

    localparam int NUM_RESOURCES = 16;
    localparam int RES_AW = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int PRIO_W = 31;
    localparam int PADDR_W = 2;

    localparam logic [PRIO_W-1:0] NO_CEILING = '1;

    localparam logic [1:0] K_LOCK   = 2'd0;
    localparam logic [1:0] K_UNLOCK = 2'd1;
    localparam logic [1:0] K_CEIL   = 2'd2;
    localparam logic [1:0] K_NONE   = 2'd3;

    localparam logic [2:0] ST_GRANTED  = 3'd0;
    localparam logic [2:0] ST_BLOCKED  = 3'd1;
    localparam logic [2:0] ST_RELEASED = 3'd2;
    localparam logic [2:0] ST_NOREL    = 3'd3;
    localparam logic [2:0] ST_CEIL_SET = 3'd4;

    localparam logic [PADDR_W-1:0] REG_MODE = '0;

    typedef struct packed {
        logic [1:0]        kind;
        logic [3:0]        resource_index;
        logic [7:0]        task_id;
        logic [15:0]       job_number;
        logic [PRIO_W-1:0] requester_priority;
        logic [PRIO_W-1:0] original_priority;
        logic [PRIO_W-1:0] ceiling_value;
    } t_cmd;

    typedef struct packed {
        logic [2:0]        status;
        logic              update_valid;
        logic [7:0]        update_task;
        logic [15:0]       update_job;
        logic [PRIO_W-1:0] update_priority;
        logic [7:0]        update_inherit_task;
        logic              update_restored;
        logic              requeue;
        logic              add_to_blocked;
    } t_result;

    typedef struct packed {
        logic              locked;
        logic [7:0]        task_id;
        logic [15:0]       job;
        logic [PRIO_W-1:0] cur;
        logic [PRIO_W-1:0] base;
    } t_owner;

endpackage

[rtl/resource_lock_priority_manager.sv]
// Resource lock manager with priority inheritance or priority ceiling. An item is taken when
// start is high and busy is low; its single result shows on o_result for one cycle with
// o_done and cannot be held off. Set ceiling, unlock of a free entry and a plain lock finish
// in the lookup state. A lock that boosts an owner, and an unlock, add a sweep over every
// resource entry that rewrites the priority of every entry owned by that job. A ceiling mode
// lock on a free entry first scans all entries for the system ceiling, one entry per cycle,
// then passes the decision state and possibly the boost state and the boost sweep. All table
// reads go through one entry read port and all priority comparisons through one shared
// comparator under the sequencer.
module resource_lock_priority_manager (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  rlpm_pkg::t_cmd          i_cmd,
    output logic                    o_done,
    output rlpm_pkg::t_result       o_result,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [rlpm_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import rlpm_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOK   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_BOOST  = 3'd4;
    localparam logic [2:0] S_SWEEP  = 3'd5;

    localparam logic [RES_AW-1:0] LAST = RES_AW'(NUM_RESOURCES - 1);

    logic [2:0]        r_state, n_state;
    logic              r_mode;
    t_cmd              r_cmd;
    logic              r_vld;
    logic [RES_AW-1:0] r_e;
    logic [RES_AW-1:0] r_cnt, n_cnt;
    logic [PRIO_W-1:0] r_sys, n_sys;
    logic [RES_AW-1:0] r_who, n_who;
    logic              r_have, n_have;
    logic [7:0]        r_tgt_task, n_tgt_task;
    logic [15:0]       r_tgt_job, n_tgt_job;
    logic [PRIO_W-1:0] r_new, n_new;
    t_result           r_res, n_res;
    logic              r_done, n_done;

    t_owner            r_own  [NUM_RESOURCES];
    logic [PRIO_W-1:0] r_ceil [NUM_RESOURCES];

    logic              accept;
    logic [RES_AW-1:0] rd_addr;
    t_owner            rd_own;
    logic [PRIO_W-1:0] rd_ceil;
    logic [PRIO_W-1:0] cmp_a, cmp_b;
    logic              cmp_lt;
    logic              own_we, ceil_we;
    logic [RES_AW-1:0] wr_addr;
    t_owner            wr_own;
    logic [PRIO_W-1:0] wr_ceil;
    logic              tgt_match, mine;
    t_owner            grant_own;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_result = r_res;
    assign pready = 1'b1;
    assign prdata = (paddr == REG_MODE) ? {31'b0, r_mode} : 32'b0;

    always_comb begin
        unique case (r_state) inside
            S_SCAN, S_SWEEP:  rd_addr = r_cnt;
            S_DECIDE, S_BOOST: rd_addr = r_who;
            default:          rd_addr = r_e;
        endcase
    end

    assign rd_own  = r_own[rd_addr];
    assign rd_ceil = r_ceil[rd_addr];

    // shared comparator
    always_comb begin
        unique case (r_state) inside
            S_SCAN: begin
                cmp_a = rd_ceil;
                cmp_b = r_sys;
            end
            S_DECIDE: begin
                cmp_a = r_cmd.requester_priority;
                cmp_b = r_sys;
            end
            default: begin
                cmp_a = r_cmd.requester_priority;
                cmp_b = rd_own.cur;
            end
        endcase
    end
    assign cmp_lt = (cmp_a < cmp_b);

    assign tgt_match = rd_own.locked && (rd_own.task_id == r_tgt_task)
                       && (rd_own.job == r_tgt_job);
    assign mine = r_have && (rd_own.task_id == r_cmd.task_id)
                  && (rd_own.job == r_cmd.job_number);

    always_comb begin
        grant_own.locked  = 1'b1;
        grant_own.task_id = r_cmd.task_id;
        grant_own.job     = r_cmd.job_number;
        grant_own.cur     = r_cmd.requester_priority;
        grant_own.base    = r_cmd.original_priority;
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_sys      = r_sys;
        n_who      = r_who;
        n_have     = r_have;
        n_tgt_task = r_tgt_task;
        n_tgt_job  = r_tgt_job;
        n_new      = r_new;
        n_res      = r_res;
        n_done     = 1'b0;
        own_we     = 1'b0;
        ceil_we    = 1'b0;
        wr_addr    = r_e;
        wr_own     = '0;
        wr_ceil    = r_cmd.ceiling_value;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res   = '0;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_cnt = '0;
                unique case (r_cmd.kind)
                    K_CEIL: begin
                        n_res.status = ST_CEIL_SET;
                        own_we  = r_vld;
                        ceil_we = r_vld;
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                    K_UNLOCK: begin
                        if (!r_vld || !rd_own.locked) begin
                            n_res.status = ST_NOREL;
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_res.status              = ST_RELEASED;
                            n_res.update_valid        = 1'b1;
                            n_res.update_task         = rd_own.task_id;
                            n_res.update_job          = rd_own.job;
                            n_res.update_priority     = rd_own.base;
                            n_res.update_inherit_task = '0;
                            n_res.update_restored     = 1'b1;
                            n_res.requeue             = 1'b1;
                            n_tgt_task = rd_own.task_id;
                            n_tgt_job  = rd_own.job;
                            n_new      = rd_own.base;
                            // entry is freed now, so the sweep leaves it alone
                            own_we  = 1'b1;
                            n_state = S_SWEEP;
                        end
                    end
                    K_LOCK: begin
                        n_res.status = ST_BLOCKED;
                        if (!r_vld) begin
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end else if (rd_own.locked) begin
                            n_res.add_to_blocked = !r_mode;
                            if (cmp_lt) begin
                                n_res.update_valid        = 1'b1;
                                n_res.update_task         = rd_own.task_id;
                                n_res.update_job          = rd_own.job;
                                n_res.update_priority     = r_cmd.requester_priority;
                                n_res.update_inherit_task = r_cmd.task_id;
                                n_res.requeue             = 1'b1;
                                n_tgt_task = rd_own.task_id;
                                n_tgt_job  = rd_own.job;
                                n_new      = r_cmd.requester_priority;
                                n_state    = S_SWEEP;
                            end else begin
                                n_done  = 1'b1;
                                n_state = S_IDLE;
                            end
                        end else if (!r_mode) begin
                            n_res.status = ST_GRANTED;
                            own_we  = 1'b1;
                            wr_own  = grant_own;
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_sys   = NO_CEILING;
                            n_who   = '0;
                            n_have  = 1'b0;
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                        n_res.status = ST_NOREL;
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SCAN: begin
                // lowest ceiling among locked entries, first index wins ties
                if (rd_own.locked && cmp_lt) begin
                    n_sys  = rd_ceil;
                    n_who  = r_cnt;
                    n_have = 1'b1;
                end
                if (r_cnt == LAST) begin
                    n_state = S_DECIDE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DECIDE: begin
                if (cmp_lt || mine) begin
                    n_res.status = ST_GRANTED;
                    own_we  = 1'b1;
                    wr_own  = grant_own;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (r_have) begin
                    n_state = S_BOOST;
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_BOOST: begin
                n_cnt = '0;
                if (cmp_lt) begin
                    n_res.update_valid        = 1'b1;
                    n_res.update_task         = rd_own.task_id;
                    n_res.update_job          = rd_own.job;
                    n_res.update_priority     = r_cmd.requester_priority;
                    n_res.update_inherit_task = r_cmd.task_id;
                    n_tgt_task = rd_own.task_id;
                    n_tgt_job  = rd_own.job;
                    n_new      = r_cmd.requester_priority;
                    n_state    = S_SWEEP;
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SWEEP: begin
                // priority belongs to the job: rewrite every entry it owns
                wr_addr = r_cnt;
                if (tgt_match) begin
                    own_we     = 1'b1;
                    wr_own     = rd_own;
                    wr_own.cur = r_new;
                end
                if (r_cnt == LAST) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_mode  <= 1'b0;
            for (int i = 0; i < NUM_RESOURCES; i++) begin
                r_own[i]  <= '0;
                r_ceil[i] <= NO_CEILING;
            end
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (psel && penable && pwrite && (paddr == REG_MODE)) begin
                r_mode <= pwdata[0];
            end
            if (own_we) begin
                r_own[wr_addr] <= wr_own;
            end
            if (ceil_we) begin
                r_ceil[wr_addr] <= wr_ceil;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
            r_vld <= (32'(i_cmd.resource_index) < NUM_RESOURCES);
            r_e   <= (32'(i_cmd.resource_index) < NUM_RESOURCES)
                     ? RES_AW'(i_cmd.resource_index) : '0;
        end
        r_cnt      <= n_cnt;
        r_sys      <= n_sys;
        r_who      <= n_who;
        r_have     <= n_have;
        r_tgt_task <= n_tgt_task;
        r_tgt_job  <= n_tgt_job;
        r_new      <= n_new;
        r_res      <= n_res;
    end

endmodule

[rtl/rlpm_chk.sv]
module rlpm_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input rlpm_pkg::t_result o_result
);
    import rlpm_pkg::*;

    // a transfer in always makes the block busy in the following cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy && $past(busy))
        else $error("result without preceding work");

    a_update_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_result.update_valid |->
            o_result.update_task == 8'd0 && o_result.update_job == 16'd0 &&
            o_result.update_priority == '0 && !o_result.update_restored &&
            !o_result.requeue)
        else $error("update fields set without update_valid");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_result.status <= ST_CEIL_SET)
        else $error("status code out of range");

    a_restore_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.update_restored |->
            o_result.status == ST_RELEASED && o_result.update_inherit_task == 8'd0)
        else $error("restore reported outside a release");

endmodule

bind resource_lock_priority_manager rlpm_chk u_rlpm_chk (.*);

[tb/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rlpm_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int TAIL_CYCLES = 40;

    logic          i_clk;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    t_cmd          cmd = '0;
    logic          done;
    t_result       result;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;

    resource_lock_priority_manager dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (cmd),
        .o_done   (done),
        .o_result (result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // shadow of the resource table and the protocol register
    logic              res_locked  [NUM_RESOURCES];
    logic [7:0]        res_task    [NUM_RESOURCES];
    logic [15:0]       res_job     [NUM_RESOURCES];
    logic [PRIO_W-1:0] res_cur     [NUM_RESOURCES];
    logic [PRIO_W-1:0] res_base    [NUM_RESOURCES];
    logic [PRIO_W-1:0] res_ceiling [NUM_RESOURCES];
    logic              protocol_ceiling = 1'b0;

    t_cmd    pending_cmds[$];
    t_result expected_results[$];
    t_result fresh_result;
    logic    fresh_valid = 1'b0;
    bit      sender_gaps = 1'b1;
    int      mismatches = 0;
    int      results_seen = 0;
    int      idle_cycles = 0;

    logic [7:0]  pool_task [5];
    logic [15:0] pool_job  [5];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void clear_entry(int e);
        res_locked[e] = 1'b0;
        res_task[e]   = '0;
        res_job[e]    = '0;
        res_cur[e]    = '0;
        res_base[e]   = '0;
    endfunction

    // a job's priority lives in every entry it holds
    function automatic void retag_job_priority(logic [7:0] t, logic [15:0] j,
                                               logic [PRIO_W-1:0] p);
        for (int i = 0; i < NUM_RESOURCES; i++)
            if (res_locked[i] && res_task[i] == t && res_job[i] == j)
                res_cur[i] = p;
    endfunction

    function automatic void raise_owner(int e, logic [PRIO_W-1:0] p, logic [7:0] from_task,
                                        bit rq, inout t_result r);
        if (p < res_cur[e]) begin
            retag_job_priority(res_task[e], res_job[e], p);
            r.update_valid        = 1'b1;
            r.update_task         = res_task[e];
            r.update_job          = res_job[e];
            r.update_priority     = p;
            r.update_inherit_task = from_task;
            r.update_restored     = 1'b0;
            r.requeue             = rq;
        end
    endfunction

    function automatic t_result arbitrate_request(t_cmd c);
        t_result           r;
        bit                in_range;
        bit                granted;
        bit                have;
        int                e;
        int                who;
        logic [PRIO_W-1:0] sys;
        r = '0;
        in_range = 32'(c.resource_index) < NUM_RESOURCES;
        e = in_range ? int'(c.resource_index) : 0;
        case (c.kind)
            K_CEIL: begin
                r.status = ST_CEIL_SET;
                if (in_range) begin
                    res_ceiling[e] = c.ceiling_value;
                    clear_entry(e);
                end
            end
            K_UNLOCK: begin
                if (!in_range || !res_locked[e]) begin
                    r.status = ST_NOREL;
                end else begin
                    retag_job_priority(res_task[e], res_job[e], res_base[e]);
                    r.update_valid        = 1'b1;
                    r.update_task         = res_task[e];
                    r.update_job          = res_job[e];
                    r.update_priority     = res_base[e];
                    r.update_inherit_task = '0;
                    r.update_restored     = 1'b1;
                    r.requeue             = 1'b1;
                    clear_entry(e);
                    r.status = ST_RELEASED;
                end
            end
            K_LOCK: begin
                if (!in_range) begin
                    r.status = ST_BLOCKED;
                end else if (res_locked[e]) begin
                    raise_owner(e, c.requester_priority, c.task_id, 1'b1, r);
                    r.status = ST_BLOCKED;
                    r.add_to_blocked = !protocol_ceiling;
                end else begin
                    granted = 1'b1;
                    if (protocol_ceiling) begin
                        sys = NO_CEILING;
                        have = 1'b0;
                        who = 0;
                        // strict less-than keeps the lowest index on ties
                        for (int i = 0; i < NUM_RESOURCES; i++)
                            if (res_locked[i] && res_ceiling[i] < sys) begin
                                sys = res_ceiling[i];
                                who = i;
                                have = 1'b1;
                            end
                        if (!(c.requester_priority < sys ||
                              (have && res_task[who] == c.task_id &&
                               res_job[who] == c.job_number))) begin
                            if (have)
                                raise_owner(who, c.requester_priority, c.task_id, 1'b0, r);
                            r.status = ST_BLOCKED;
                            granted = 1'b0;
                        end
                    end
                    if (granted) begin
                        res_locked[e] = 1'b1;
                        res_task[e]   = c.task_id;
                        res_job[e]    = c.job_number;
                        res_cur[e]    = c.requester_priority;
                        res_base[e]   = c.original_priority;
                        r.status = ST_GRANTED;
                    end
                end
            end
            default: r.status = ST_NOREL;
        endcase
        return r;
    endfunction

    function automatic void log_mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on result %0d, %s: expected %h, got %h",
                     results_seen, what, exp_v, act_v);
    endfunction

    function automatic void check_result(t_result exp_r, t_result act_r);
        if (act_r.status !== exp_r.status)
            log_mismatch("status", 32'(exp_r.status), 32'(act_r.status));
        if (act_r.update_valid !== exp_r.update_valid)
            log_mismatch("update_valid", 32'(exp_r.update_valid), 32'(act_r.update_valid));
        if (act_r.update_task !== exp_r.update_task)
            log_mismatch("update_task", 32'(exp_r.update_task), 32'(act_r.update_task));
        if (act_r.update_job !== exp_r.update_job)
            log_mismatch("update_job", 32'(exp_r.update_job), 32'(act_r.update_job));
        if (act_r.update_priority !== exp_r.update_priority)
            log_mismatch("update_priority", 32'(exp_r.update_priority),
                         32'(act_r.update_priority));
        if (act_r.update_inherit_task !== exp_r.update_inherit_task)
            log_mismatch("update_inherit_task", 32'(exp_r.update_inherit_task),
                         32'(act_r.update_inherit_task));
        if (act_r.update_restored !== exp_r.update_restored)
            log_mismatch("update_restored", 32'(exp_r.update_restored),
                         32'(act_r.update_restored));
        if (act_r.requeue !== exp_r.requeue)
            log_mismatch("requeue", 32'(exp_r.requeue), 32'(act_r.requeue));
        if (act_r.add_to_blocked !== exp_r.add_to_blocked)
            log_mismatch("add_to_blocked", 32'(exp_r.add_to_blocked),
                         32'(act_r.add_to_blocked));
    endfunction

    // driver: predicts at the accepting edge, then presents the next command
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            fresh_valid <= 1'b0;
        end else begin
            fresh_valid <= start && !busy;
            if (start && !busy)
                fresh_result <= arbitrate_request(cmd);
            if (!start || !busy) begin
                if (pending_cmds.size() > 0 && (!sender_gaps || $urandom_range(99) >= 31)) begin
                    start <= 1'b1;
                    cmd <= pending_cmds.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: expectation of a transfer is queued from the registered fresh_valid, before any compare
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (fresh_valid)
                expected_results.push_back(fresh_result);
            if (done) begin
                if (expected_results.size() == 0)
                    log_mismatch("result with nothing expected", '0, 32'(result.status));
                else
                    check_result(expected_results.pop_front(), result);
                results_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || done || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_cmds.size() > 0 || start || fresh_valid ||
               expected_results.size() > 0 || busy)
            @(posedge i_clk);
    endtask

    task automatic write_mode(logic m);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_MODE;
        pwdata <= {31'b0, m};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        protocol_ceiling = m;
        // read it back
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {31'b0, m})
            log_mismatch("mode readback", {31'b0, m}, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic push_cmd(logic [1:0] k, logic [3:0] idx, logic [7:0] t, logic [15:0] j,
                            logic [PRIO_W-1:0] p, logic [PRIO_W-1:0] b,
                            logic [PRIO_W-1:0] ceil);
        t_cmd c;
        c.kind = k;
        c.resource_index = idx;
        c.task_id = t;
        c.job_number = j;
        c.requester_priority = p;
        c.original_priority = b;
        c.ceiling_value = ceil;
        pending_cmds.push_back(c);
    endtask

    // mostly small priorities so that comparisons tie and cross often
    function automatic logic [PRIO_W-1:0] pick_prio();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60) return PRIO_W'($urandom_range(40));
        if (sel < 85) return PRIO_W'($urandom_range(1000));
        if (sel < 95) return PRIO_W'($urandom);
        return ($urandom_range(1) != 0) ? NO_CEILING : '0;
    endfunction

    function automatic logic [PRIO_W-1:0] pick_ceiling();
        int sel;
        sel = $urandom_range(99);
        if (sel < 35) return NO_CEILING;
        if (sel < 75) return PRIO_W'($urandom_range(60, 20));
        if (sel < 90) return PRIO_W'($urandom_range(40));
        return PRIO_W'($urandom);
    endfunction

    task automatic push_random_cmd();
        int                sel;
        int                who;
        logic [1:0]        k;
        logic [7:0]        t;
        logic [15:0]       j;
        logic [PRIO_W-1:0] p;
        logic [PRIO_W-1:0] b;
        sel = $urandom_range(99);
        if (sel < 45)      k = K_LOCK;
        else if (sel < 75) k = K_UNLOCK;
        else if (sel < 93) k = K_CEIL;
        else               k = K_NONE;
        who = $urandom_range(4);
        if ($urandom_range(99) < 75) begin
            t = pool_task[who];
            j = pool_job[who];
        end else begin
            t = 8'($urandom);
            j = 16'($urandom);
        end
        p = pick_prio();
        b = ($urandom_range(1) != 0) ? pick_prio() : p + PRIO_W'($urandom_range(20));
        push_cmd(k, 4'($urandom_range(15)), t, j, p, b, pick_ceiling());
    endtask

    task automatic run_phase(logic m, int count, bit gaps);
        wait_idle();
        write_mode(m);
        sender_gaps = gaps;
        for (int n = 0; n < count; n++)
            push_random_cmd();
        wait_idle();
    endtask

    initial begin
        for (int i = 0; i < NUM_RESOURCES; i++) begin
            clear_entry(i);
            res_ceiling[i] = NO_CEILING;
        end
        for (int i = 0; i < 5; i++) begin
            pool_task[i] = 8'($urandom);
            pool_job[i] = 16'($urandom);
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // inheritance mode straight out of reset
        push_cmd(K_UNLOCK, 4'd0, 8'h11, 16'h0001, 31'd20, 31'd30, NO_CEILING);
        push_cmd(K_NONE,   4'd9, 8'hff, 16'hffff, NO_CEILING, NO_CEILING, NO_CEILING);
        push_cmd(K_LOCK,   4'd0, 8'h11, 16'h0001, 31'd20, 31'd30, '0);
        push_cmd(K_LOCK,   4'd5, 8'h11, 16'h0001, 31'd20, 31'd25, '0);
        // boost must reach both entries held by the same job
        push_cmd(K_LOCK,   4'd0, 8'h22, 16'h0002, 31'd10, 31'd10, '0);
        push_cmd(K_LOCK,   4'd0, 8'h33, 16'h0003, 31'd50, 31'd50, '0);
        push_cmd(K_UNLOCK, 4'd0, 8'h11, 16'h0001, '0, '0, '0);
        // ceiling write frees without restore
        push_cmd(K_CEIL,   4'd5, 8'h00, 16'h0000, '0, '0, '0);
        push_cmd(K_LOCK,   4'd15, 8'hff, 16'hffff, NO_CEILING, NO_CEILING, NO_CEILING);
        push_cmd(K_LOCK,   4'd15, 8'h00, 16'h0000, '0, '0, '0);
        push_cmd(K_UNLOCK, 4'd15, 8'h00, 16'h0000, '0, '0, '0);
        push_cmd(K_CEIL,   4'd15, 8'hff, 16'hffff, NO_CEILING, NO_CEILING, NO_CEILING);
        wait_idle();

        write_mode(1'b1);
        push_cmd(K_CEIL,   4'd3, 8'h00, 16'h0000, '0, '0, 31'd10);
        push_cmd(K_CEIL,   4'd4, 8'h00, 16'h0000, '0, '0, 31'd10);
        push_cmd(K_CEIL,   4'd7, 8'h00, 16'h0000, '0, '0, 31'd5);
        push_cmd(K_LOCK,   4'd3, 8'h11, 16'h0001, 31'd20, 31'd30, '0);
        // equal to the system ceiling is not enough, owner gets boosted without requeue
        push_cmd(K_LOCK,   4'd4, 8'h22, 16'h0002, 31'd10, 31'd10, '0);
        // the ceiling owner itself passes
        push_cmd(K_LOCK,   4'd4, 8'h11, 16'h0001, 31'd30, 31'd30, '0);
        push_cmd(K_LOCK,   4'd3, 8'h33, 16'h0003, 31'd1, 31'd1, '0);
        // two locked entries tie on ceiling 10, lower index decides
        push_cmd(K_LOCK,   4'd7, 8'h33, 16'h0003, 31'd2, 31'd4, '0);
        push_cmd(K_LOCK,   4'd8, 8'h44, 16'h0004, 31'd5, 31'd5, '0);
        push_cmd(K_UNLOCK, 4'd3, 8'h00, 16'h0000, '0, '0, '0);
        push_cmd(K_UNLOCK, 4'd4, 8'h00, 16'h0000, '0, '0, '0);
        push_cmd(K_UNLOCK, 4'd7, 8'h00, 16'h0000, '0, '0, '0);
        // no locked entry at all and requester at the lowest urgency
        push_cmd(K_LOCK,   4'd8, 8'h44, 16'h0004, NO_CEILING, NO_CEILING, '0);
        wait_idle();

        run_phase(1'b0, 400, 1'b1);
        run_phase(1'b1, 400, 1'b1);
        run_phase(1'b0, 350, 1'b0);
        run_phase(1'b1, 500, 1'b1);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
